// ===== rtl/core/wgs_pkg.sv =====
// wgs_pkg: shared types, action codes and the drop kernel for the wave grid engine
// no dependencies; used by wave_grid_stencil_engine_top and wgs_step_alu
package wgs_pkg;

    // action codes of a command item
    localparam logic [1:0] ACT_DROP = 2'd0;
    localparam logic [1:0] ACT_STEP = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    // drop kernel reach around the centre cell and its last offset index
    localparam int KERNEL_REACH = 4;
    localparam logic [3:0] KERNEL_LAST = 4'd8;

    // height word and datapath widths
    localparam int HW = 32;
    localparam int ACC_W = 34;
    localparam int KW = 15;
    localparam int AMP_W = 22;
    localparam int INC_W = 26;

    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  cell_x;
        logic [5:0]  cell_y;
        logic [21:0] amplitude;
        logic [15:0] wave_speed;
        logic [15:0] damping;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] cell_value;
        logic               saturated;
    } rsp_t;

    // status from the stencil arithmetic pipeline
    typedef struct packed {
        logic               done;
        logic               sat;
        logic signed [31:0] value;
    } alu_out_t;

    // gaussian weight, unsigned Q0.16, indexed by absolute row and column offset
    function automatic logic [KW-1:0] kernel_weight(input logic [2:0] aj, input logic [2:0] ai);
        logic [KW-1:0] w;
        begin
            case ({aj, ai})
                {3'd0, 3'd0}: w = 15'd22938;
                {3'd0, 3'd1}: w = 15'd17864;
                {3'd0, 3'd2}: w = 15'd8438;
                {3'd0, 3'd3}: w = 15'd2418;
                {3'd0, 3'd4}: w = 15'd420;
                {3'd1, 3'd0}: w = 15'd17864;
                {3'd1, 3'd1}: w = 15'd13912;
                {3'd1, 3'd2}: w = 15'd6572;
                {3'd1, 3'd3}: w = 15'd1883;
                {3'd1, 3'd4}: w = 15'd327;
                {3'd2, 3'd0}: w = 15'd8438;
                {3'd2, 3'd1}: w = 15'd6572;
                {3'd2, 3'd2}: w = 15'd3104;
                {3'd2, 3'd3}: w = 15'd889;
                {3'd2, 3'd4}: w = 15'd155;
                {3'd3, 3'd0}: w = 15'd2418;
                {3'd3, 3'd1}: w = 15'd1883;
                {3'd3, 3'd2}: w = 15'd889;
                {3'd3, 3'd3}: w = 15'd255;
                {3'd3, 3'd4}: w = 15'd44;
                {3'd4, 3'd0}: w = 15'd420;
                {3'd4, 3'd1}: w = 15'd327;
                {3'd4, 3'd2}: w = 15'd155;
                {3'd4, 3'd3}: w = 15'd44;
                {3'd4, 3'd4}: w = 15'd8;
                default:      w = '0;
            endcase
            return w;
        end
    endfunction

endpackage

// ===== rtl/core/wave_grid_stencil_engine_top.sv =====
// wave_grid_stencil_engine_top: command sequencer around the height memory
// depends on wgs_pkg, wgs_ram and wgs_step_alu
//
// Usage: one command item enters on cmd (valid/stall) and gives exactly one
// response item on rsp (valid/stall). An item is taken when valid is high and
// stall is low. Commands run one at a time; cmd_stall is high while a command
// is in progress, a new command may enter while a response still waits.
// Both time planes of a cell share one 64-bit memory word, one read port.
// Work per item:
//   read  : one memory read of the addressed cell
//   drop  : read, increment and write for each of 81 kernel cells
//   step  : per grid cell, cell and four neighbour reads, five-stage
//           arithmetic pipeline, one write
// Reset: after rst_n rises the memory is cleared one word per cycle, all
// GRID_W*GRID_H words, with cmd_stall high; the current plane is 0.
// A stalled response holds; a finished command waits until the response
// register is free.
module wave_grid_stencil_engine_top #(
    parameter int GRID_W = 64,
    parameter int GRID_H = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  wgs_pkg::cmd_t  cmd,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output wgs_pkg::rsp_t  rsp
);
    import wgs_pkg::*;

    localparam int XW = $clog2(GRID_W);
    localparam int YW = $clog2(GRID_H);
    localparam int CELLS = GRID_W * GRID_H;
    localparam int AW = $clog2(CELLS);
    localparam int CW = 12;
    localparam int NSUBX = 63 / GRID_W;
    localparam int NSUBY = 63 / GRID_H;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_READ_DATA,
        ST_DROP_RD,
        ST_DROP_INC,
        ST_DROP_WR,
        ST_STEP_C,
        ST_STEP_L,
        ST_STEP_R,
        ST_STEP_D,
        ST_STEP_U,
        ST_STEP_SUM,
        ST_STEP_ALU,
        ST_DONE
    } state_t;

    state_t              state_reg;
    cmd_t                cmd_reg;
    logic                plane_reg;
    logic                flag_reg;
    logic signed [31:0]  value_reg;
    logic                rsp_valid_reg;
    rsp_t                rsp_reg;
    logic [AW-1:0]       clr_cnt_reg;
    logic [3:0]          dx_reg;
    logic [3:0]          dy_reg;
    logic [36:0]         prod_reg;
    logic [INC_W-1:0]    inc_reg;
    logic [XW-1:0]       si_reg;
    logic [YW-1:0]       sj_reg;
    logic signed [31:0]  vc_reg;
    logic signed [31:0]  vp_reg;
    logic signed [ACC_W-1:0] acc_reg;

    logic [CW-1:0]       xv;
    logic [CW-1:0]       yv;
    logic [XW-1:0]       cx_m;
    logic [YW-1:0]       cy_m;
    logic [CW-1:0]       tx;
    logic [CW-1:0]       ty;
    logic [XW-1:0]       drop_x;
    logic [YW-1:0]       drop_y;
    logic [2:0]          ax;
    logic [2:0]          ay;
    logic [41:0]         prod20;
    logic [41:0]         inc_sum;
    logic [XW-1:0]       im;
    logic [XW-1:0]       ip;
    logic [YW-1:0]       jm;
    logic [YW-1:0]       jp;

    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    logic [2*HW-1:0]     ram_wr_data;
    logic [AW-1:0]       ram_rd_addr;
    logic [2*HW-1:0]     ram_rd_data;

    logic signed [31:0]  rd_cur;
    logic signed [31:0]  rd_prev;
    logic signed [32:0]  dsum0;
    logic signed [32:0]  dsum1;
    logic [31:0]         dval0;
    logic [31:0]         dval1;
    logic                drop_sat;
    logic [2*HW-1:0]     drop_word;
    logic [2*HW-1:0]     step_word;
    logic                alu_start;
    logic signed [33:0]  alu_nsum;
    alu_out_t            alu_out;

    function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] x, input logic [YW-1:0] y);
        begin
            return AW'(y) * AW'(GRID_W) + AW'(x);
        end
    endfunction

    // command coordinates reduced into the grid
    always_comb
    begin
        xv = CW'(cmd_reg.cell_x);
        for (int k = 0; k < NSUBX; k++)
        begin
            if (xv >= CW'(GRID_W))
            begin
                xv = xv - CW'(GRID_W);
            end
        end
        yv = CW'(cmd_reg.cell_y);
        for (int k = 0; k < NSUBY; k++)
        begin
            if (yv >= CW'(GRID_H))
            begin
                yv = yv - CW'(GRID_H);
            end
        end
        cx_m = xv[XW-1:0];
        cy_m = yv[YW-1:0];
    end

    // drop cell position with toroidal wrap and kernel offsets
    always_comb
    begin
        tx = CW'(cx_m) + CW'(dx_reg) + CW'(GRID_W - KERNEL_REACH);
        if (tx >= CW'(GRID_W))
        begin
            tx = tx - CW'(GRID_W);
        end
        if (tx >= CW'(GRID_W))
        begin
            tx = tx - CW'(GRID_W);
        end
        ty = CW'(cy_m) + CW'(dy_reg) + CW'(GRID_H - KERNEL_REACH);
        if (ty >= CW'(GRID_H))
        begin
            ty = ty - CW'(GRID_H);
        end
        if (ty >= CW'(GRID_H))
        begin
            ty = ty - CW'(GRID_H);
        end
        drop_x = tx[XW-1:0];
        drop_y = ty[YW-1:0];
        ax = (dx_reg >= 4'd4) ? 3'(dx_reg - 4'd4) : 3'(4'd4 - dx_reg);
        ay = (dy_reg >= 4'd4) ? 3'(dy_reg - 4'd4) : 3'(4'd4 - dy_reg);
    end

    // drop increment: weight times amplitude times twenty, rounded
    always_comb
    begin
        prod20 = {1'b0, prod_reg, 4'b0} + {3'b0, prod_reg, 2'b0};
        inc_sum = prod20 + 42'd32768;
    end

    // drop add to both planes with upper clamp
    always_comb
    begin
        dsum0 = 33'($signed(ram_rd_data[31:0])) + $signed({7'b0, inc_reg});
        dsum1 = 33'($signed(ram_rd_data[63:32])) + $signed({7'b0, inc_reg});
        dval0 = (dsum0 > 33'sd2147483647) ? 32'h7fffffff : dsum0[31:0];
        dval1 = (dsum1 > 33'sd2147483647) ? 32'h7fffffff : dsum1[31:0];
        drop_sat = (dsum0 > 33'sd2147483647) || (dsum1 > 33'sd2147483647);
        drop_word = {dval1, dval0};
    end

    // step neighbours with wrap
    always_comb
    begin
        im = (si_reg == '0) ? XW'(GRID_W - 1) : si_reg - 1'b1;
        ip = (si_reg == XW'(GRID_W - 1)) ? '0 : si_reg + 1'b1;
        jm = (sj_reg == '0) ? YW'(GRID_H - 1) : sj_reg - 1'b1;
        jp = (sj_reg == YW'(GRID_H - 1)) ? '0 : sj_reg + 1'b1;
    end

    // plane views of the read word
    always_comb
    begin
        rd_cur = plane_reg ? $signed(ram_rd_data[63:32]) : $signed(ram_rd_data[31:0]);
        rd_prev = plane_reg ? $signed(ram_rd_data[31:0]) : $signed(ram_rd_data[63:32]);
        step_word = plane_reg ? {vc_reg, alu_out.value} : {alu_out.value, vc_reg};
        alu_start = (state_reg == ST_STEP_SUM);
        alu_nsum = acc_reg + ACC_W'(rd_cur);
    end

    // memory port control
    always_comb
    begin
        ram_wr_en = 1'b0;
        ram_wr_addr = '0;
        ram_wr_data = '0;
        ram_rd_addr = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_wr_en = 1'b1;
                ram_wr_addr = clr_cnt_reg;
            end
            ST_READ:
            begin
                ram_rd_addr = addr_of(cx_m, cy_m);
            end
            ST_DROP_RD, ST_DROP_INC:
            begin
                ram_rd_addr = addr_of(drop_x, drop_y);
            end
            ST_DROP_WR:
            begin
                ram_rd_addr = addr_of(drop_x, drop_y);
                ram_wr_en = 1'b1;
                ram_wr_addr = addr_of(drop_x, drop_y);
                ram_wr_data = drop_word;
            end
            ST_STEP_C:
            begin
                ram_rd_addr = addr_of(si_reg, sj_reg);
            end
            ST_STEP_L:
            begin
                ram_rd_addr = addr_of(im, sj_reg);
            end
            ST_STEP_R:
            begin
                ram_rd_addr = addr_of(ip, sj_reg);
            end
            ST_STEP_D:
            begin
                ram_rd_addr = addr_of(si_reg, jm);
            end
            ST_STEP_U:
            begin
                ram_rd_addr = addr_of(si_reg, jp);
            end
            ST_STEP_ALU:
            begin
                ram_wr_en = alu_out.done;
                ram_wr_addr = addr_of(si_reg, sj_reg);
                ram_wr_data = step_word;
            end
            default:
            begin
                ram_rd_addr = '0;
            end
        endcase
    end

    wgs_ram #(
        .WIDTH (2 * HW),
        .DEPTH (CELLS)
    ) u_height_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    wgs_step_alu u_step_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (alu_start),
        .vc     (vc_reg),
        .vp     (vp_reg),
        .nsum   (alu_nsum),
        .speed  (cmd_reg.wave_speed),
        .damp   (cmd_reg.damping),
        .result (alu_out)
    );

    // sequencer, state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_cnt_reg <= '0;
            plane_reg <= 1'b0;
            flag_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            dx_reg <= '0;
            dy_reg <= '0;
            si_reg <= '0;
            sj_reg <= '0;
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall && state_reg != ST_DONE)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == AW'(CELLS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg <= cmd;
                        flag_reg <= 1'b0;
                        value_reg <= '0;
                        dx_reg <= '0;
                        dy_reg <= '0;
                        si_reg <= '0;
                        sj_reg <= '0;
                        case (cmd.action)
                            ACT_DROP: state_reg <= ST_DROP_RD;
                            ACT_STEP: state_reg <= ST_STEP_C;
                            ACT_READ: state_reg <= ST_READ;
                            default:  state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_READ_DATA;
                end
                ST_READ_DATA:
                begin
                    value_reg <= rd_cur;
                    state_reg <= ST_DONE;
                end
                ST_DROP_RD:
                begin
                    prod_reg <= 37'(kernel_weight(ay, ax)) * 37'(cmd_reg.amplitude);
                    state_reg <= ST_DROP_INC;
                end
                ST_DROP_INC:
                begin
                    inc_reg <= inc_sum[41:16];
                    state_reg <= ST_DROP_WR;
                end
                ST_DROP_WR:
                begin
                    flag_reg <= flag_reg | drop_sat;
                    state_reg <= ST_DROP_RD;
                    if (dx_reg == KERNEL_LAST)
                    begin
                        dx_reg <= '0;
                        if (dy_reg == KERNEL_LAST)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            dy_reg <= dy_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        dx_reg <= dx_reg + 1'b1;
                    end
                end
                ST_STEP_C:
                begin
                    state_reg <= ST_STEP_L;
                end
                ST_STEP_L:
                begin
                    vc_reg <= rd_cur;
                    vp_reg <= rd_prev;
                    state_reg <= ST_STEP_R;
                end
                ST_STEP_R:
                begin
                    acc_reg <= ACC_W'(rd_cur);
                    state_reg <= ST_STEP_D;
                end
                ST_STEP_D:
                begin
                    acc_reg <= acc_reg + ACC_W'(rd_cur);
                    state_reg <= ST_STEP_U;
                end
                ST_STEP_U:
                begin
                    acc_reg <= acc_reg + ACC_W'(rd_cur);
                    state_reg <= ST_STEP_SUM;
                end
                ST_STEP_SUM:
                begin
                    state_reg <= ST_STEP_ALU;
                end
                ST_STEP_ALU:
                begin
                    if (alu_out.done)
                    begin
                        flag_reg <= flag_reg | alu_out.sat;
                        state_reg <= ST_STEP_C;
                        if (si_reg == XW'(GRID_W - 1))
                        begin
                            si_reg <= '0;
                            if (sj_reg == YW'(GRID_H - 1))
                            begin
                                plane_reg <= ~plane_reg;
                                state_reg <= ST_DONE;
                            end
                            else
                            begin
                                sj_reg <= sj_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            si_reg <= si_reg + 1'b1;
                        end
                    end
                end
                ST_DONE:
                begin
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_valid_reg <= 1'b1;
                        rsp_reg.cell_value <= value_reg;
                        rsp_reg.saturated <= flag_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign cmd_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

endmodule

// ===== rtl/core/wgs_ram.sv =====
// wgs_ram: generic single write port, single read port ram with registered read
// no dependencies
module wgs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/core/wgs_step_alu.sv =====
// wgs_step_alu: pipelined leapfrog update of one cell (laplacian, speed and damping products)
// depends on wgs_pkg
module wgs_step_alu (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [31:0]        vc,
    input  logic signed [31:0]        vp,
    input  logic signed [33:0]        nsum,
    input  logic [15:0]               speed,
    input  logic [15:0]               damp,
    output wgs_pkg::alu_out_t         result
);
    import wgs_pkg::*;

    logic [3:0]          vld_reg;
    logic signed [34:0]  lap_reg;
    logic signed [31:0]  vc_reg;
    logic signed [31:0]  vp_reg;
    logic signed [51:0]  prod1_reg;
    logic signed [37:0]  val_reg;
    logic signed [54:0]  prod2_reg;
    logic signed [51:0]  rsum1;
    logic signed [35:0]  rnd1;
    logic signed [37:0]  val_next;
    logic signed [54:0]  rsum2;
    logic signed [38:0]  rnd2;
    logic signed [31:0]  sat_value;
    logic                sat_hit;
    alu_out_t            result_reg;

    // rounding of the speed product and the leapfrog sum
    always_comb
    begin
        rsum1 = prod1_reg + 52'sd32768;
        rnd1 = $signed(rsum1[51:16]);
        val_next = (38'(vc_reg) <<< 1) - 38'(vp_reg) + 38'(rnd1);
    end

    // rounding of the damping product and clamp to 32 bits
    always_comb
    begin
        rsum2 = prod2_reg + 55'sd32768;
        rnd2 = $signed(rsum2[54:16]);
        sat_hit = 1'b0;
        sat_value = rnd2[31:0];
        if (rnd2 > 39'sd2147483647)
        begin
            sat_hit = 1'b1;
            sat_value = 32'sh7fffffff;
        end
        else if (rnd2 < -39'sd2147483648)
        begin
            sat_hit = 1'b1;
            sat_value = 32'sh80000000;
        end
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            result_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], start};
            result_reg.done <= vld_reg[3];
            if (vld_reg[3])
            begin
                result_reg.sat <= sat_hit;
                result_reg.value <= sat_value;
            end
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            lap_reg <= 35'(nsum) - (35'(vc) <<< 2);
            vc_reg <= vc;
            vp_reg <= vp;
        end
        prod1_reg <= $signed({1'b0, speed}) * lap_reg;
        val_reg <= val_next;
        prod2_reg <= val_reg * $signed({1'b0, damp});
    end

    assign result = result_reg;

endmodule

// ===== test/tb_wave_grid_stencil_engine_top.sv =====
// tb_wave_grid_stencil_engine_top: drives drop, step, read and undefined-action items into the engine
// and checks every response against a behavioral grid model or a typed row's own expected response
module tb_wave_grid_stencil_engine_top;
    timeunit 1ns;
    timeprecision 1ps;
    import wgs_pkg::*;

    localparam int GW = 64;
    localparam int GH = 64;
    localparam int N_RANDOM = 124;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    wave_grid_stencil_engine_top #(.GRID_W(GW), .GRID_H(GH)) dut (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // model state: two planes of heights and the current plane pointer
    logic signed [31:0] plane_hgt [2][GW*GH] = '{default: '0};
    bit cur_plane;
    bit clamp_seen;

    rsp_t expected_rsp_q[$];
    int mismatches = 0;
    int sender_idle_pct = 31;
    int recv_idle_pct = 88;
    bit long_hold_req = 1'b0;

    // gaussian weights indexed by absolute row and column offset
    int unsigned gauss_w [5][5] = '{
        '{22938, 17864, 8438, 2418, 420},
        '{17864, 13912, 6572, 1883, 327},
        '{8438, 6572, 3104, 889, 155},
        '{2418, 1883, 889, 255, 44},
        '{420, 327, 155, 44, 8}
    };

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            clamp_seen = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            clamp_seen = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // round to nearest at the q16 point, floor of the half-offset sum
    function automatic longint round16(input longint v);
        return (v + 32768) >>> 16;
    endfunction

    function automatic rsp_t wave_model_apply(input cmd_t c);
        rsp_t r;
        longint inc, lap, val, vp, vc;
        int x, y, im, ip, jm, jp;
        bit prv;
        r = '0;
        clamp_seen = 1'b0;
        case (c.action)
            ACT_DROP:
            begin
                for (int dj = -4; dj <= 4; dj++)
                begin
                    for (int di = -4; di <= 4; di++)
                    begin
                        inc = (longint'(gauss_w[dj < 0 ? -dj : dj][di < 0 ? -di : di])
                               * longint'(c.amplitude) * 20 + 32768) >>> 16;
                        x = (int'(c.cell_x) + GW + di) % GW;
                        y = (int'(c.cell_y) + GH + dj) % GH;
                        for (int p = 0; p < 2; p++)
                            plane_hgt[p][y*GW + x] =
                                clamp32(longint'(plane_hgt[p][y*GW + x]) + inc);
                    end
                end
            end
            ACT_STEP:
            begin
                prv = ~cur_plane;
                for (int j = 0; j < GH; j++)
                begin
                    jm = (j == 0) ? GH - 1 : j - 1;
                    jp = (j == GH - 1) ? 0 : j + 1;
                    for (int i = 0; i < GW; i++)
                    begin
                        im = (i == 0) ? GW - 1 : i - 1;
                        ip = (i == GW - 1) ? 0 : i + 1;
                        vp = plane_hgt[prv][j*GW + i];
                        vc = plane_hgt[cur_plane][j*GW + i];
                        lap = longint'(plane_hgt[cur_plane][j*GW + im])
                            + longint'(plane_hgt[cur_plane][j*GW + ip])
                            + longint'(plane_hgt[cur_plane][jm*GW + i])
                            + longint'(plane_hgt[cur_plane][jp*GW + i]) - 4 * vc;
                        val = 2 * vc - vp + round16(longint'(c.wave_speed) * lap);
                        plane_hgt[prv][j*GW + i] = clamp32(round16(val * longint'(c.damping)));
                    end
                end
                cur_plane = prv;
            end
            ACT_READ:
                r.cell_value = plane_hgt[cur_plane][int'(c.cell_y)*GW + int'(c.cell_x)];
            default: ;
        endcase
        r.saturated = clamp_seen;
        return r;
    endfunction

    // directed rows; typed rows carry their own expected response
    typedef struct {
        logic [1:0] act;
        int x, y, amp, spd, dmp;
        bit typed;
        int val;
        bit sat;
    } dir_row_t;

    localparam int N_DIR = 17;
    dir_row_t dir_tab [N_DIR] = '{
        '{ACT_READ, 0, 0, 0, 0, 0, 1, 0, 0},
        '{ACT_READ, 63, 63, 4194303, 65535, 65535, 1, 0, 0},
        '{2'd3, 63, 0, 4194303, 65535, 65535, 1, 0, 0},
        '{ACT_DROP, 0, 0, 4194303, 0, 0, 0, 0, 0},
        '{ACT_DROP, 63, 63, 0, 0, 0, 1, 0, 0},
        '{ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ACT_READ, 60, 60, 0, 0, 0, 0, 0, 0},
        '{ACT_READ, 4, 4, 0, 0, 0, 0, 0, 0},
        '{ACT_DROP, 32, 32, 4194303, 0, 0, 0, 0, 0},
        '{ACT_STEP, 0, 0, 0, 32768, 65535, 0, 0, 0},
        '{ACT_READ, 32, 32, 0, 0, 0, 0, 0, 0},
        '{ACT_READ, 31, 32, 0, 0, 0, 0, 0, 0},
        '{ACT_STEP, 0, 0, 0, 65535, 65535, 0, 0, 0},
        '{ACT_STEP, 0, 0, 0, 0, 0, 1, 0, 0},
        '{ACT_READ, 32, 32, 0, 0, 0, 1, 0, 0},
        '{ACT_DROP, 5, 5, 1, 0, 0, 0, 0, 0},
        '{ACT_READ, 5, 5, 0, 0, 0, 0, 0, 0}
    };

    // offer one item and hold it until the engine takes it
    task automatic send_item(input cmd_t c, input bit typed, input rsp_t typed_rsp);
        rsp_t e;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            cmd_valid <= 1'b0;
            cmd <= cmd_t'({$urandom, $urandom, $urandom});
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        forever
        begin
            @(posedge clk);
            if (!cmd_stall)
                break;
        end
        e = wave_model_apply(c);
        expected_rsp_q.push_back(typed ? typed_rsp : e);
        @(negedge clk);
    endtask

    // stimulus
    initial
    begin
        cmd_t c;
        rsp_t t;
        int hot_x [4];
        int hot_y [4];
        int k, h;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int n = 0; n < N_DIR; n++)
        begin
            c = '0;
            c.action = dir_tab[n].act;
            c.cell_x = 6'(dir_tab[n].x);
            c.cell_y = 6'(dir_tab[n].y);
            c.amplitude = 22'(dir_tab[n].amp);
            c.wave_speed = 16'(dir_tab[n].spd);
            c.damping = 16'(dir_tab[n].dmp);
            t.cell_value = dir_tab[n].val;
            t.saturated = dir_tab[n].sat;
            send_item(c, dir_tab[n].typed, t);
        end
        for (int n = 0; n < 4; n++)
        begin
            hot_x[n] = $urandom_range(63);
            hot_y[n] = $urandom_range(63);
        end
        hot_x[0] = 62;
        hot_y[0] = 1;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM / 3)
            begin
                sender_idle_pct = 88;
                recv_idle_pct = 31;
            end
            if (n == 2 * N_RANDOM / 3)
            begin
                sender_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (n == 60)
                long_hold_req = 1'b1;
            if (n == 95)
            begin
                cmd_valid <= 1'b0;
                wait (expected_rsp_q.size() == 0);
                @(negedge clk);
            end
            c = cmd_t'({$urandom, $urandom, $urandom});
            k = $urandom_range(99);
            h = $urandom_range(3);
            if (k < 55)
            begin
                c.action = ACT_DROP;
                if ($urandom_range(2) != 0)
                begin
                    c.cell_x = 6'(hot_x[h]);
                    c.cell_y = 6'(hot_y[h]);
                end
                if ($urandom_range(1) != 0)
                    c.amplitude = 22'(22'h3fffff - $urandom_range(255));
            end
            else if (k < 92)
            begin
                c.action = ACT_READ;
                if ($urandom_range(1) != 0)
                begin
                    c.cell_x = 6'(hot_x[h] + $urandom_range(2) - 1);
                    c.cell_y = 6'(hot_y[h] + $urandom_range(2) - 1);
                end
            end
            else if (k < 96)
            begin
                c.action = ACT_STEP;
                if ($urandom_range(1) != 0)
                    c.damping = 16'(16'hffff - $urandom_range(63));
            end
            else
                c.action = 2'd3;
            send_item(c, 1'b0, '0);
        end
        cmd_valid <= 1'b0;
        wait (expected_rsp_q.size() == 0);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("tb_wave_grid_stencil_engine_top OK");
        else
            $display("tb_wave_grid_stencil_engine_top NOT OK");
        $finish;
    end

    // response side stall, with one long hold-off
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                rsp_stall <= 1'b1;
                repeat (2000) @(negedge clk);
            end
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // response checker
    always @(posedge clk)
    begin
        rsp_t e;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response value=%0d sat=%0b",
                             rsp.cell_value, rsp.saturated);
            end
            else
            begin
                e = expected_rsp_q.pop_front();
                if (rsp.cell_value !== e.cell_value || rsp.saturated !== e.saturated)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected value=%0d sat=%0b, got value=%0d sat=%0b",
                                 e.cell_value, e.saturated, rsp.cell_value, rsp.saturated);
                end
            end
        end
    end

    // overall time limit
    initial
    begin
        #40000000;
        $display("tb_wave_grid_stencil_engine_top NOT OK");
        $finish;
    end

endmodule
